FILE: rtl/core/smn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package smn_pkg;

   localparam int WORD_W      = 64;
   localparam int SHIFT_W     = 7;
   localparam int CNT_W       = 6;
   localparam int COARSE_STEP = 8;

   localparam logic [CNT_W-1:0]   MUL_LAST    = CNT_W'(WORD_W - 1);
   localparam logic [SHIFT_W-1:0] COARSE_INC  = SHIFT_W'(COARSE_STEP);
   localparam logic [SHIFT_W-1:0] FINE_INC    = SHIFT_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_NORM,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic mul_step;
      logic norm_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic top_set;
      logic zero;
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/core/smn_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface smn_req_if;
   import smn_pkg::*;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] multiplicand;
   logic [WORD_W-1:0] multiplier;

   modport source (output valid, output multiplicand, output multiplier, input ready);
   modport sink   (input valid, input multiplicand, input multiplier, output ready);
endinterface

interface smn_rsp_if;
   import smn_pkg::*;
   logic               valid;
   logic               ready;
   logic [WORD_W-1:0]  product_high;
   logic [WORD_W-1:0]  product_low;
   logic               top_bit_set;
   logic [SHIFT_W-1:0] extra_shift;

   modport source (output valid, output product_high, output product_low,
                   output top_bit_set, output extra_shift, input ready);
   modport sink   (input valid, input product_high, input product_low,
                   input top_bit_set, input extra_shift, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/smn_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module smn_datapath
   import smn_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   input  wire  cmd_type       cmd,
   input  wire  [WORD_W-1:0]   multiplicand,
   input  wire  [WORD_W-1:0]   multiplier,
   output status_type          status,
   output logic [WORD_W-1:0]   product_high,
   output logic [WORD_W-1:0]   product_low,
   output logic                top_bit_set,
   output logic [SHIFT_W-1:0]  extra_shift
);

   logic [WORD_W-1:0]  hi_ff, hi_in;
   logic [WORD_W-1:0]  lo_ff, lo_in;
   logic [WORD_W-1:0]  mcand_ff, mcand_in;
   logic               zero_ff, zero_in;
   logic [SHIFT_W-1:0] nshift_ff, nshift_in;
   logic [WORD_W-1:0]  out_hi_ff, out_hi_in;
   logic [WORD_W-1:0]  out_lo_ff, out_lo_in;
   logic               out_flag_ff, out_flag_in;
   logic [SHIFT_W-1:0] out_shift_ff, out_shift_in;
   logic [WORD_W:0]    sum;

   // add the multiplicand when the current multiplier bit is set
   assign sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : {(WORD_W+1){1'b0}});

   always_comb begin
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      mcand_in     = mcand_ff;
      zero_in      = zero_ff;
      nshift_in    = nshift_ff;
      out_hi_in    = out_hi_ff;
      out_lo_in    = out_lo_ff;
      out_flag_in  = out_flag_ff;
      out_shift_in = out_shift_ff;
      if (cmd.load) begin
         hi_in     = '0;
         lo_in     = multiplier;
         mcand_in  = multiplicand;
         zero_in   = (multiplicand == '0) || (multiplier == '0);
         nshift_in = '0;
      end else if (cmd.mul_step) begin
         hi_in = sum[WORD_W:1];
         lo_in = {sum[0], lo_ff[WORD_W-1:1]};
      end else if (cmd.norm_step) begin
         // coarse step while the top byte is clear, then single bits
         if (hi_ff[WORD_W-1 -: COARSE_STEP] == '0) begin
            {hi_in, lo_in} = {hi_ff, lo_ff} << COARSE_STEP;
            nshift_in      = nshift_ff + COARSE_INC;
         end else begin
            {hi_in, lo_in} = {hi_ff, lo_ff} << 1;
            nshift_in      = nshift_ff + FINE_INC;
         end
      end
      if (cmd.out_load) begin
         out_hi_in    = hi_ff;
         out_lo_in    = lo_ff;
         out_flag_in  = !zero_ff && (nshift_ff == '0);
         out_shift_in = (zero_ff || nshift_ff == '0) ? '0 : nshift_ff - FINE_INC;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff        <= hi_in;
      lo_ff        <= lo_in;
      mcand_ff     <= mcand_in;
      zero_ff      <= zero_in;
      nshift_ff    <= nshift_in;
      out_hi_ff    <= out_hi_in;
      out_lo_ff    <= out_lo_in;
      out_flag_ff  <= out_flag_in;
      out_shift_ff <= out_shift_in;
   end

   assign status.top_set = hi_ff[WORD_W-1];
   assign status.zero    = zero_ff;

   assign product_high = out_hi_ff;
   assign product_low  = out_lo_ff;
   assign top_bit_set  = out_flag_ff;
   assign extra_shift  = out_shift_ff;

`ifndef SYNTHESIS
   a_norm_not_done: assert property (@(posedge clock) disable iff (reset)
      cmd.norm_step |-> !hi_ff[WORD_W-1])
      else $error("normalize step issued on an already normalized product");
   a_out_normalized: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load && !zero_ff |=> out_hi_ff[WORD_W-1])
      else $error("nonzero result leaves without its top bit set");
   a_out_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load && zero_ff |=> out_hi_ff == '0 && out_lo_ff == '0 && !out_flag_ff)
      else $error("zero operand did not give a zero result");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/smn_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module smn_ctrl
   import smn_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   input  wire  status_type status,
   output cmd_type     cmd
);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               out_valid_ff, out_valid_in;
   logic               out_free;

   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MUL;
         end
         ST_MUL: begin
            if (cnt_ff == MUL_LAST) state_in = status.zero ? ST_FINISH : ST_NORM;
         end
         ST_NORM: begin
            if (status.top_set) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE:   begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_MUL:    cmd.mul_step  = 1'b1;
         ST_NORM:   cmd.norm_step = !status.top_set;
         ST_FINISH: cmd.out_load  = out_free;
         default:   cmd = '0;
      endcase
   end

   // iteration count for the multiply loop
   assign cnt_in = (state_ff == ST_MUL) ? cnt_ff + 1'b1 : '0;

   assign out_valid_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   assign rsp_valid    = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_starts_mul: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_MUL && cnt_ff == '0)
      else $error("accepted word did not start the multiply loop");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !out_valid_ff || rsp_ready)
      else $error("output register overwritten while still pending");
   a_mul_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL && cnt_ff == MUL_LAST |=> state_ff == ST_NORM || state_ff == ST_FINISH)
      else $error("multiply loop ran past its last bit");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/significand_multiply_normalize.sv
`timescale 1ns / 1ps
`default_nettype none

// Unsigned 64x64 significand multiply with normalization. Each request word carries
// two 64-bit operands; the response word holds the full 128-bit product shifted left
// until bit 127 is set, a flag that is 1 when the raw product was already normalized,
// and the leading-zero count minus one otherwise. A zero operand gives an all-zero
// response. One request is in flight at a time: the accept, the shift-add multiply loop
// over all 64 multiplier bits (one multiplier bit per cycle through a 65-bit adder),
// the normalize state (up to 22 shifts, 8 bits while the top byte is clear, then
// single bits, ending when bit 127 is seen set; skipped for a zero operand) and the
// load of the output register. The load waits while the output register still
// holds an untaken response. The output register holds a finished response while
// the next request is already taken and worked on.
module significand_multiply_normalize
   import smn_pkg::*;
(
   input  wire       clock,
   input  wire       reset,
   smn_req_if.sink   req_chan,
   smn_rsp_if.source rsp_chan
);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;
   logic       rsp_valid;

   // sequencer: owns the handshakes, the loop count and the response valid
   smn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // operand, product and output registers
   smn_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .multiplicand (req_chan.multiplicand),
      .multiplier   (req_chan.multiplier),
      .status       (status),
      .product_high (rsp_chan.product_high),
      .product_low  (rsp_chan.product_low),
      .top_bit_set  (rsp_chan.top_bit_set),
      .extra_shift  (rsp_chan.extra_shift)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import smn_pkg::*;

   // One expected or observed response word.
   typedef struct packed {
      logic [WORD_W-1:0]  hi;
      logic [WORD_W-1:0]  lo;
      logic               top;
      logic [SHIFT_W-1:0] shift;
   } norm_word_type;

   // One row of the directed table. Rows with fixed set carry a hand-written
   // answer; the others are checked against norm_product.
   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic              fixed;
      norm_word_type     want;
   } stim_row_type;

   localparam logic [WORD_W-1:0] ALL_ONES = '1;
   localparam logic [WORD_W-1:0] MSB_ONLY = 64'h8000_0000_0000_0000;

   localparam int RANDOM_WORDS    = 1800;
   localparam int GAP_MAX         = 18;
   localparam int MODE_SPAN       = 150;  // words between idle-mode redraws
   localparam int PRESSURE_AT     = 40;   // response count that starts the long hold-off
   localparam int PRESSURE_CYCLES = 600;
   localparam int DRAIN_CYCLES    = 100;  // beyond the worst case per word
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int REPORT_MAX      = 10;

   localparam int DIRECTED_COUNT = 22;
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // zero operands give an all-zero word
      '{64'h0,    64'h0,    1'b1, '{64'h0, 64'h0, 1'b0, 7'd0}},
      '{64'h0,    ALL_ONES, 1'b1, '{64'h0, 64'h0, 1'b0, 7'd0}},
      '{ALL_ONES, 64'h0,    1'b1, '{64'h0, 64'h0, 1'b0, 7'd0}},
      // smallest nonzero product: deepest shift
      '{64'h1,    64'h1,    1'b1, '{MSB_ONLY, 64'h0, 1'b0, 7'd126}},
      // largest product: already normalized
      '{ALL_ONES, ALL_ONES, 1'b1, '{64'hFFFF_FFFF_FFFF_FFFE, 64'h1, 1'b1, 7'd0}},
      // bit 126 set: one shift, counted as zero
      '{MSB_ONLY, MSB_ONLY, 1'b1, '{MSB_ONLY, 64'h0, 1'b0, 7'd0}},
      '{MSB_ONLY, 64'h2,    1'b1, '{MSB_ONLY, 64'h0, 1'b0, 7'd62}},
      '{MSB_ONLY, 64'h1,    1'b1, '{MSB_ONLY, 64'h0, 1'b0, 7'd63}},
      '{64'h1,    ALL_ONES, 1'b1, '{ALL_ONES, 64'h0, 1'b0, 7'd63}},
      '{ALL_ONES, 64'h1,    1'b1, '{ALL_ONES, 64'h0, 1'b0, 7'd63}},
      '{MSB_ONLY, 64'h3,                   1'b0, '0},
      '{64'hFFFF_FFFF,           64'hFFFF_FFFF,           1'b0, '0},
      '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
      '{64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF, 1'b0, '0},
      '{64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001, 1'b0, '0},
      '{64'h0000_0001_0000_0000, 64'h0000_0001_0000_0000, 1'b0, '0},
      '{64'h00FF_FFFF_FFFF_FFFF, 64'h00FF_FFFF_FFFF_FFFF, 1'b0, '0},
      '{64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b0, '0},
      '{64'h7FFF_FFFF_FFFF_FFFF, 64'h2,                   1'b0, '0},
      '{64'hB504_F333_F9DE_6484, 64'hB504_F333_F9DE_6485, 1'b0, '0},
      '{ALL_ONES, MSB_ONLY,                1'b0, '0},
      '{64'h3,    64'h1,                   1'b0, '0}
   };

   logic clock;
   logic reset;

   smn_req_if req_bus ();
   smn_rsp_if rsp_bus ();

   significand_multiply_normalize u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source)
   );

   norm_word_type pending_products [$];
   int            mismatch_count = 0;
   int            results_seen   = 0;
   int            idle_cycles    = 0;
   bit            req_quiet      = 1'b0;
   bit            rsp_quiet      = 1'b0;

   always #1 clock = ~clock;

   // Full 128-bit product, shifted left until bit 127 is set. The shift count
   // excludes the first step; a zero operand leaves everything at zero.
   function automatic norm_word_type norm_product(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
      logic [2*WORD_W-1:0] raw;
      norm_word_type       r;
      int                  lz;
      r   = '0;
      raw = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
      lz  = 0;
      if (a != '0 && b != '0) begin
         if (raw[2*WORD_W-1]) begin
            r.top = 1'b1;
         end else begin
            while (!raw[2*WORD_W-1]) begin
               raw = raw << 1;
               lz++;
            end
            r.shift = SHIFT_W'(lz - 1);
         end
         r.hi = raw[2*WORD_W-1:WORD_W];
         r.lo = raw[WORD_W-1:0];
      end
      return r;
   endfunction

   // Mix operand shapes: short operands push the product deep into the
   // normalize loop, full-width ones land near the already-normalized case.
   function automatic logic [WORD_W-1:0] draw_significand();
      logic [WORD_W-1:0] v;
      int                kind;
      v    = {$urandom, $urandom};
      kind = $urandom_range(0, 15);
      case (kind)
         0: begin
            v = ($urandom_range(0, 1) == 0) ? '0 : v;
         end
         1: begin
            v = ALL_ONES;
         end
         2, 3: begin
            v = WORD_W'(1) << $urandom_range(0, WORD_W - 1);
         end
         4, 5, 6, 7, 8: begin
            v = v >> $urandom_range(1, WORD_W - 1);
         end
         9: begin
            v = v | MSB_ONLY;
         end
         default: begin
         end
      endcase
      return v;
   endfunction

   // Offer one request word after a random gap, hold it until taken, then
   // queue its expected response. Keep valid high across back-to-back words.
   task automatic send_word(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
                            input logic fixed, input norm_word_type fixed_want);
      int            gap;
      norm_word_type expect_word;
      gap = req_quiet ? 0 : $urandom_range(0, GAP_MAX);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.multiplicand <= a;
      req_bus.multiplier   <= b;
      do @(posedge clock); while (!req_bus.ready);
      expect_word      = fixed ? fixed_want : norm_product(a, b);
      pending_products = {pending_products, expect_word};
   endtask

   // Request side: reset, directed table, then random words.
   initial begin : stimulus
      clock                = 1'b0;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.multiplicand = '0;
      req_bus.multiplier   = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_ROWS[i]) begin
         send_word(DIRECTED_ROWS[i].a, DIRECTED_ROWS[i].b,
                   DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want);
      end

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         // redraw the idle mode now and then so busy and quiet stretches alternate
         if (n % MODE_SPAN == 0) begin
            req_quiet = ($urandom_range(0, 3) == 0);
         end
         send_word(draw_significand(), draw_significand(), 1'b0, '0);
      end
      req_bus.valid <= 1'b0;

      // drain: wait for every queued response, then give the block time to
      // emit anything spurious
      while (pending_products.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_products.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Response side: stall at random, once for a long stretch so the output
   // register and the working stage both fill and the request side backs up.
   initial begin : collect
      norm_word_type want;
      norm_word_type got;
      int            stall;
      rsp_bus.ready = 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (results_seen % MODE_SPAN == 0) begin
            rsp_quiet = ($urandom_range(0, 3) == 0);
         end
         stall = rsp_quiet ? 0 : $urandom_range(0, GAP_MAX);
         if (results_seen == PRESSURE_AT) begin
            stall = PRESSURE_CYCLES;
         end
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);

         got.hi    = rsp_bus.product_high;
         got.lo    = rsp_bus.product_low;
         got.top   = rsp_bus.top_bit_set;
         got.shift = rsp_bus.extra_shift;
         results_seen++;

         if (pending_products.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
               $display("unexpected response: hi=%h lo=%h top=%b shift=%0d",
                        got.hi, got.lo, got.top, got.shift);
            end
         end else begin
            want = pending_products.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX) begin
                  $display("response %0d: expected hi=%h lo=%h top=%b shift=%0d",
                           results_seen, want.hi, want.lo, want.top, want.shift);
                  $display("response %0d: actual   hi=%h lo=%h top=%b shift=%0d",
                           results_seen, got.hi, got.lo, got.top, got.shift);
               end
            end
         end
      end
   end

   // Watchdog: drop the run when neither channel moves a word for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

endmodule

FILE: filelist.f
rtl/core/smn_pkg.sv
rtl/core/smn_if.sv
rtl/core/smn_datapath.sv
rtl/core/smn_ctrl.sv
rtl/core/significand_multiply_normalize.sv
test/testbench.sv
